@@ rtl/sprs_pkg.sv @@
// Shared types and constants for the slotted page row store.
// Field widths, request and status codes, sequencer states and the result record.
// No dependencies.
package sprs_pkg;

  localparam int unsigned SLOT_BYTES    = 4;

  localparam int unsigned REQ_TYPE_W    = 3;
  localparam int unsigned SLOT_INDEX_W  = 10;
  localparam int unsigned ROW_LEN_W     = 13;
  localparam int unsigned DATA_BYTE_W   = 8;
  localparam int unsigned BYTE_INDEX_W  = 12;
  localparam int unsigned PAGE_ID_W     = 32;

  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned SLOT_OUT_W    = 10;
  localparam int unsigned ROW_OFFSET_W  = 12;
  localparam int unsigned ROW_LEN_OUT_W = 13;
  localparam int unsigned BYTE_OUT_W    = 8;
  localparam int unsigned SLOT_COUNT_W  = 11;
  localparam int unsigned FREE_BYTES_W  = 13;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_INIT      = 3'd0,
    REQ_INSERT    = 3'd1,
    REQ_READ      = 3'd2,
    REQ_DELETE    = 3'd3,
    REQ_UPDATE    = 3'd4,
    REQ_DATA      = 3'd5,
    REQ_READ_BYTE = 3'd6
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BADLEN  = 3'd1,
    ST_FULL    = 3'd2,
    ST_OOB     = 3'd3,
    ST_DELETED = 3'd4,
    ST_NOPEND  = 3'd5,
    ST_BEYOND  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_BYTE
  } state_e;

  typedef struct packed {
    logic dir_we;
    logic page_we;
    logic byte_rd;
  } exec_ctl_t;

  typedef struct packed {
    status_e                  status;
    logic [SLOT_OUT_W-1:0]    slot_out;
    logic [ROW_OFFSET_W-1:0]  row_offset;
    logic [ROW_LEN_OUT_W-1:0] row_len_out;
    logic [BYTE_OUT_W-1:0]    byte_out;
    logic [SLOT_COUNT_W-1:0]  slot_count;
    logic [FREE_BYTES_W-1:0]  free_bytes;
    logic                     dirty;
  } result_t;

endpackage

@@ rtl/sprs_exec.sv @@
// Request evaluation for the slotted page row store: checks, allocation and next page state.
// Works on the directory entry read for the request and the page bookkeeping registers.
// Depends on sprs_pkg.
module sprs_exec import sprs_pkg::*; #(
  parameter int unsigned PAGE_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 4,
  parameter int unsigned MAX_SLOTS    = 1024,
  localparam int unsigned PAGE_AW = $clog2(PAGE_BYTES),
  localparam int unsigned PTR_W   = $clog2(PAGE_BYTES + 1),
  localparam int unsigned CNT_W   = $clog2(MAX_SLOTS + 1),
  localparam int unsigned DIR_AW  = $clog2(MAX_SLOTS)
) (
  input  req_e                    req_i,
  input  logic [SLOT_INDEX_W-1:0] slot_i,
  input  logic [ROW_LEN_W-1:0]    len_i,
  input  logic [BYTE_INDEX_W-1:0] bidx_i,
  input  logic [CNT_W-1:0]        slots_used_i,
  input  logic [PTR_W-1:0]        free_ptr_i,
  input  logic [PTR_W-1:0]        pending_i,
  input  logic [PAGE_AW-1:0]      fill_i,
  input  logic                    modified_i,
  input  logic [PAGE_AW-1:0]      dir_off_i,
  input  logic [PTR_W-1:0]        dir_len_i,
  output logic [CNT_W-1:0]        slots_used_o,
  output logic [PTR_W-1:0]        free_ptr_o,
  output logic [PTR_W-1:0]        pending_o,
  output logic [PAGE_AW-1:0]      fill_o,
  output logic                    modified_o,
  output logic [DIR_AW-1:0]       dir_waddr_o,
  output logic [PAGE_AW-1:0]      dir_off_o,
  output logic [PTR_W-1:0]        dir_len_o,
  output logic [PAGE_AW-1:0]      page_addr_o,
  output exec_ctl_t               ctl_o,
  output result_t                 res_o
);

  localparam int unsigned CW0 = (PTR_W > ROW_LEN_W) ? PTR_W : ROW_LEN_W;
  localparam int unsigned CW1 = (CW0 > CNT_W + 3) ? CW0 : CNT_W + 3;
  localparam int unsigned CW  = CW1 + 1;

  logic [CW-1:0] len_c, fp_c, dir_end, space, dir_end_d, space_d, fp_d_c;
  logic [CW-1:0] alloc_off, off_out, len_out;
  logic          oob, dead, dir_full;
  status_e       st;
  logic [SLOT_OUT_W-1:0] slot_out;

  assign len_c     = CW'(len_i);
  assign fp_c      = CW'(free_ptr_i);
  assign dir_end   = CW'(HEADER_BYTES) + CW'(slots_used_i) * CW'(SLOT_BYTES);
  assign space     = (fp_c >= dir_end) ? fp_c - dir_end : '0;
  assign alloc_off = fp_c - len_c;
  assign oob       = CW'(slot_i) >= CW'(slots_used_i);
  assign dead      = (dir_len_i == '0);
  assign dir_full  = CW'(slots_used_i) >= CW'(MAX_SLOTS);

  always_comb begin
    slots_used_o = slots_used_i;
    free_ptr_o   = free_ptr_i;
    pending_o    = pending_i;
    fill_o       = fill_i;
    modified_o   = modified_i;
    dir_waddr_o  = DIR_AW'(slot_i);
    dir_off_o    = dir_off_i;
    dir_len_o    = dir_len_i;
    page_addr_o  = fill_i;
    ctl_o        = '0;
    st           = ST_OK;
    slot_out     = '0;
    off_out      = '0;
    len_out      = '0;
    case (req_i)
      REQ_INIT: begin
        slots_used_o = '0;
        free_ptr_o   = PTR_W'(PAGE_BYTES);
        pending_o    = '0;
        fill_o       = '0;
        modified_o   = 1'b0;
      end
      REQ_INSERT: begin
        if (len_c == '0) begin
          st = ST_BADLEN;
        end else if (dir_full || space < len_c + CW'(SLOT_BYTES)) begin
          st = ST_FULL;
        end else begin
          dir_waddr_o  = DIR_AW'(slots_used_i);
          dir_off_o    = PAGE_AW'(alloc_off);
          dir_len_o    = PTR_W'(len_c);
          ctl_o.dir_we = 1'b1;
          slot_out     = SLOT_OUT_W'(slots_used_i);
          slots_used_o = slots_used_i + CNT_W'(1);
          free_ptr_o   = PTR_W'(alloc_off);
          modified_o   = 1'b1;
          pending_o    = PTR_W'(len_c);
          fill_o       = PAGE_AW'(alloc_off);
          off_out      = alloc_off;
          len_out      = len_c;
        end
      end
      REQ_READ: begin
        if (oob) begin
          st = ST_OOB;
        end else if (dead) begin
          st = ST_DELETED;
        end else begin
          off_out = CW'(dir_off_i);
          len_out = CW'(dir_len_i);
        end
      end
      REQ_DELETE: begin
        if (oob) begin
          st = ST_OOB;
        end else if (dead) begin
          st = ST_DELETED;
        end else begin
          off_out      = CW'(dir_off_i);
          dir_len_o    = '0;
          ctl_o.dir_we = 1'b1;
          modified_o   = 1'b1;
        end
      end
      REQ_UPDATE: begin
        if (oob) begin
          st = ST_OOB;
        end else if (dead) begin
          st = ST_DELETED;
        end else if (len_c == '0) begin
          st = ST_BADLEN;
        end else if (len_c > CW'(dir_len_i) && space < len_c) begin
          st = ST_FULL;
        end else begin
          // Relocate a growing row to fresh space; the old bytes leak.
          if (len_c > CW'(dir_len_i)) begin
            dir_off_o  = PAGE_AW'(alloc_off);
            free_ptr_o = PTR_W'(alloc_off);
          end
          dir_len_o    = PTR_W'(len_c);
          ctl_o.dir_we = 1'b1;
          modified_o   = 1'b1;
          pending_o    = PTR_W'(len_c);
          fill_o       = dir_off_o;
          off_out      = CW'(dir_off_o);
          len_out      = len_c;
        end
      end
      REQ_DATA: begin
        if (pending_i == '0) begin
          st = ST_NOPEND;
        end else begin
          ctl_o.page_we = 1'b1;
          off_out       = CW'(fill_i);
          fill_o        = fill_i + PAGE_AW'(1);
          pending_o     = pending_i - PTR_W'(1);
        end
      end
      REQ_READ_BYTE: begin
        if (oob) begin
          st = ST_OOB;
        end else if (dead) begin
          st = ST_DELETED;
        end else if (CW'(bidx_i) >= CW'(dir_len_i)) begin
          st = ST_BEYOND;
        end else begin
          ctl_o.byte_rd = 1'b1;
          page_addr_o   = PAGE_AW'(CW'(dir_off_i) + CW'(bidx_i));
          off_out       = CW'(dir_off_i);
          len_out       = CW'(dir_len_i);
        end
      end
      default: begin
      end
    endcase
  end

  assign fp_d_c    = CW'(free_ptr_o);
  assign dir_end_d = CW'(HEADER_BYTES) + CW'(slots_used_o) * CW'(SLOT_BYTES);
  assign space_d   = (fp_d_c >= dir_end_d) ? fp_d_c - dir_end_d : '0;

  always_comb begin
    res_o.status      = st;
    res_o.slot_out    = slot_out;
    res_o.row_offset  = ROW_OFFSET_W'(off_out);
    res_o.row_len_out = ROW_LEN_OUT_W'(len_out);
    res_o.byte_out    = '0;
    res_o.slot_count  = SLOT_COUNT_W'(slots_used_o);
    res_o.free_bytes  = FREE_BYTES_W'(space_d);
    res_o.dirty       = modified_o;
  end

endmodule

@@ rtl/slotted_page_row_store_unit.sv @@
// Slotted page row store: page bytes and slot directory in two synchronous RAMs.
// Sequencing: the request and its directory entry are registered at accept, evaluated and
// written back in the evaluate state, then loaded into the output register; read row byte
// adds a page read state. A new request is taken only once the previous result is loaded.
// Reset: asynchronous, active low; clears slot count, pointers, pending count and dirty.
// The RAM contents are not cleared; rows are defined only after their bytes arrive.
module slotted_page_row_store_unit import sprs_pkg::*; #(
  parameter int unsigned PAGE_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 4,
  parameter int unsigned MAX_SLOTS    = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [REQ_TYPE_W-1:0]    req_type_i,
  input  logic [SLOT_INDEX_W-1:0]  slot_index_i,
  input  logic [ROW_LEN_W-1:0]     row_len_i,
  input  logic [DATA_BYTE_W-1:0]   data_byte_i,
  input  logic [BYTE_INDEX_W-1:0]  byte_index_i,
  input  logic [PAGE_ID_W-1:0]     page_id_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [SLOT_OUT_W-1:0]    slot_out_o,
  output logic [ROW_OFFSET_W-1:0]  row_offset_o,
  output logic [ROW_LEN_OUT_W-1:0] row_len_out_o,
  output logic [BYTE_OUT_W-1:0]    byte_out_o,
  output logic [SLOT_COUNT_W-1:0]  slot_count_o,
  output logic [FREE_BYTES_W-1:0]  free_bytes_o,
  output logic                     dirty_o
);

  localparam int unsigned PAGE_AW = $clog2(PAGE_BYTES);
  localparam int unsigned PTR_W   = $clog2(PAGE_BYTES + 1);
  localparam int unsigned CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int unsigned DIR_AW  = $clog2(MAX_SLOTS);
  localparam int unsigned DIR_W   = PAGE_AW + PTR_W;

  // Sequencer and output register
  state_e state_q, state_d;
  logic   out_valid_q;
  result_t res_q, res_d;
  logic   accept, out_free, commit, load_res;
  logic   dir_re, dir_we, page_re, page_we;

  // Request registers
  req_e                    req_q;
  logic [SLOT_INDEX_W-1:0] slot_q;
  logic [ROW_LEN_W-1:0]    len_q;
  logic [DATA_BYTE_W-1:0]  dbyte_q;
  logic [BYTE_INDEX_W-1:0] bidx_q;

  // Page bookkeeping
  logic [CNT_W-1:0]     slots_used_q, slots_used_d;
  logic [PTR_W-1:0]     free_ptr_q, free_ptr_d;
  logic [PTR_W-1:0]     pending_q, pending_d;
  logic [PAGE_AW-1:0]   fill_q, fill_d;
  logic                 modified_q, modified_d;
  logic [PAGE_ID_W-1:0] current_page_q;

  // Memories
  logic [DIR_W-1:0]       dir_mem [MAX_SLOTS];
  logic [DIR_W-1:0]       dir_rdata_q;
  logic [DATA_BYTE_W-1:0] page_mem [PAGE_BYTES];
  logic [DATA_BYTE_W-1:0] page_rdata_q;

  logic [DIR_AW-1:0]  dir_waddr;
  logic [PAGE_AW-1:0] dir_woff;
  logic [PTR_W-1:0]   dir_wlen;
  logic [PAGE_AW-1:0] page_addr;
  exec_ctl_t          ctl;
  result_t            exec_res;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Evaluate the held request against the directory entry read at accept time.
  sprs_exec #(
    .PAGE_BYTES  (PAGE_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_exec (
    .req_i       (req_q),
    .slot_i      (slot_q),
    .len_i       (len_q),
    .bidx_i      (bidx_q),
    .slots_used_i(slots_used_q),
    .free_ptr_i  (free_ptr_q),
    .pending_i   (pending_q),
    .fill_i      (fill_q),
    .modified_i  (modified_q),
    .dir_off_i   (dir_rdata_q[DIR_W-1:PTR_W]),
    .dir_len_i   (dir_rdata_q[PTR_W-1:0]),
    .slots_used_o(slots_used_d),
    .free_ptr_o  (free_ptr_d),
    .pending_o   (pending_d),
    .fill_o      (fill_d),
    .modified_o  (modified_d),
    .dir_waddr_o (dir_waddr),
    .dir_off_o   (dir_woff),
    .dir_len_o   (dir_wlen),
    .page_addr_o (page_addr),
    .ctl_o       (ctl),
    .res_o       (exec_res)
  );

  // Next state: accept in idle, evaluate, then fetch the page byte for read row byte.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (ctl.byte_rd) begin
          state_d = S_BYTE;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_BYTE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready_o = 1'b0;
    dir_re     = 1'b0;
    dir_we     = 1'b0;
    page_re    = 1'b0;
    page_we    = 1'b0;
    commit     = 1'b0;
    load_res   = 1'b0;
    res_d      = exec_res;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        dir_re     = in_valid_i;
      end
      S_EXEC: begin
        // Read row byte changes nothing; issue the page read and hold the result.
        page_re = ctl.byte_rd;
        if (out_free && !ctl.byte_rd) begin
          commit   = 1'b1;
          load_res = 1'b1;
          dir_we   = ctl.dir_we;
          page_we  = ctl.page_we;
        end
      end
      S_BYTE: begin
        load_res       = out_free;
        res_d.byte_out = page_rdata_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      out_valid_q    <= 1'b0;
      slots_used_q   <= '0;
      free_ptr_q     <= PTR_W'(PAGE_BYTES);
      pending_q      <= '0;
      fill_q         <= '0;
      modified_q     <= 1'b0;
      current_page_q <= '0;
    end else begin
      state_q <= state_d;
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (commit) begin
        slots_used_q <= slots_used_d;
        free_ptr_q   <= free_ptr_d;
        pending_q    <= pending_d;
        fill_q       <= fill_d;
        modified_q   <= modified_d;
      end
      // Record the page identifier as soon as an init request is taken.
      if (accept && req_type_i == REQ_INIT) begin
        current_page_q <= page_id_i;
      end
    end
  end

  // Hold the request fields for the evaluate state.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_e'(req_type_i);
      slot_q  <= slot_index_i;
      len_q   <= row_len_i;
      dbyte_q <= data_byte_i;
      bidx_q  <= byte_index_i;
    end
    if (load_res) begin
      res_q <= res_d;
    end
  end

  // Slot directory: {offset, length} per slot, one read and one write port.
  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= {dir_woff, dir_wlen};
    end
    if (dir_re) begin
      dir_rdata_q <= dir_mem[DIR_AW'(slot_index_i)];
    end
  end

  // Page bytes: row data written at the fill pointer, read for read row byte.
  always_ff @(posedge clk_i) begin
    if (page_we) begin
      page_mem[page_addr] <= dbyte_q;
    end
    if (page_re) begin
      page_rdata_q <= page_mem[page_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_q.status;
  assign slot_out_o    = res_q.slot_out;
  assign row_offset_o  = res_q.row_offset;
  assign row_len_out_o = res_q.row_len_out;
  assign byte_out_o    = res_q.byte_out;
  assign slot_count_o  = res_q.slot_count;
  assign free_bytes_o  = res_q.free_bytes;
  assign dirty_o       = res_q.dirty;

endmodule

@@ tb/slotted_page_row_store_unit_test.sv @@
// Self-checking testbench for slotted_page_row_store_unit.
// It holds its own page image, slot directory and reply queue, and checks every reply.
// Depends on sprs_pkg and the unit itself.
module slotted_page_row_store_unit_test;
  import sprs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAGE_BYTES     = 4096;
  localparam int unsigned HEADER_BYTES   = 4;
  localparam int unsigned MAX_SLOTS      = 1024;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RANDOM_ITEMS   = 1425;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;

  // One request as the sender drives it.
  typedef struct packed {
    req_e                    kind;
    logic [SLOT_INDEX_W-1:0] slot;
    logic [ROW_LEN_W-1:0]    len;
    logic [DATA_BYTE_W-1:0]  dbyte;
    logic [BYTE_INDEX_W-1:0] bidx;
    logic [PAGE_ID_W-1:0]    pid;
  } request_t;

  // Shadow page plus the queue of replies the unit still owes.
  class page_scoreboard;
    bit [7:0]    row_bytes[PAGE_BYTES];
    bit          byte_written[PAGE_BYTES];
    int unsigned slot_off[MAX_SLOTS];
    int unsigned slot_len[MAX_SLOTS];
    int unsigned used;
    int unsigned free_ptr;
    int unsigned pend;
    int unsigned fill;
    bit          modified;
    bit [31:0]   page_tag;
    result_t     owed_replies[$];
    int          errors;

    function new();
      free_ptr = PAGE_BYTES;
    endfunction

    function int unsigned room();
      int unsigned dir_end;
      dir_end = HEADER_BYTES + used * SLOT_BYTES;
      return (free_ptr >= dir_end) ? free_ptr - dir_end : 0;
    endfunction

    function status_e slot_state(int unsigned s);
      if (s >= used || s >= MAX_SLOTS) return ST_OOB;
      if (slot_len[s] == 0) return ST_DELETED;
      return ST_OK;
    endfunction

    // Apply one request to the shadow page and return the reply it earns.
    function result_t advance_page(request_t r);
      result_t     res;
      int unsigned off;
      res = '0;
      res.status = ST_OK;
      case (r.kind)
        REQ_INIT: begin
          modified = 1'b0;
          page_tag = r.pid;
          used     = 0;
          free_ptr = PAGE_BYTES;
          pend     = 0;
          fill     = 0;
        end
        REQ_INSERT: begin
          if (r.len == 0) begin
            res.status = ST_BADLEN;
          end else if (used >= MAX_SLOTS || room() < r.len + SLOT_BYTES) begin
            res.status = ST_FULL;
          end else begin
            off = free_ptr - r.len;
            slot_off[used]  = off;
            slot_len[used]  = r.len;
            res.slot_out    = SLOT_OUT_W'(used);
            used++;
            free_ptr        = off;
            modified        = 1'b1;
            pend            = r.len;
            fill            = off;
            res.row_offset  = ROW_OFFSET_W'(off);
            res.row_len_out = r.len;
          end
        end
        REQ_READ: begin
          res.status = slot_state(r.slot);
          if (res.status == ST_OK) begin
            res.row_offset  = ROW_OFFSET_W'(slot_off[r.slot]);
            res.row_len_out = ROW_LEN_OUT_W'(slot_len[r.slot]);
          end
        end
        REQ_DELETE: begin
          res.status = slot_state(r.slot);
          if (res.status == ST_OK) begin
            res.row_offset   = ROW_OFFSET_W'(slot_off[r.slot]);
            slot_len[r.slot] = 0;
            modified         = 1'b1;
          end
        end
        REQ_UPDATE: begin
          res.status = slot_state(r.slot);
          if (res.status == ST_OK && r.len == 0) res.status = ST_BADLEN;
          if (res.status == ST_OK) begin
            if (r.len > slot_len[r.slot] && room() < r.len) begin
              res.status = ST_FULL;
            end else begin
              // Growth moves the row to fresh space; the old bytes are leaked.
              if (r.len > slot_len[r.slot]) begin
                off = free_ptr - r.len;
                slot_off[r.slot] = off;
                free_ptr = off;
              end else begin
                off = slot_off[r.slot];
              end
              slot_len[r.slot] = r.len;
              modified         = 1'b1;
              pend             = r.len;
              fill             = off;
              res.row_offset   = ROW_OFFSET_W'(off);
              res.row_len_out  = r.len;
            end
          end
        end
        REQ_DATA: begin
          if (pend == 0) begin
            res.status = ST_NOPEND;
          end else begin
            if (fill < PAGE_BYTES) begin
              row_bytes[fill]    = r.dbyte;
              byte_written[fill] = 1'b1;
            end
            res.row_offset = ROW_OFFSET_W'(fill);
            fill++;
            pend--;
          end
        end
        REQ_READ_BYTE: begin
          res.status = slot_state(r.slot);
          if (res.status == ST_OK) begin
            if (r.bidx >= slot_len[r.slot]) begin
              res.status = ST_BEYOND;
            end else begin
              off = slot_off[r.slot] + r.bidx;
              res.row_offset  = ROW_OFFSET_W'(slot_off[r.slot]);
              res.row_len_out = ROW_LEN_OUT_W'(slot_len[r.slot]);
              res.byte_out    = (off < PAGE_BYTES) ? row_bytes[off] : 8'd0;
            end
          end
        end
        default: ;
      endcase
      res.slot_count = SLOT_COUNT_W'(used);
      res.free_bytes = FREE_BYTES_W'(room());
      res.dirty      = modified;
      return res;
    endfunction

    function void note_request(request_t r);
      owed_replies.push_back(advance_page(r));
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_replies.size() == 0) begin
        errors++;
        $error("reply arrived with no request outstanding");
        return;
      end
      want = owed_replies.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("slot_out", want.slot_out, got.slot_out);
      compare_field("row_offset", want.row_offset, got.row_offset);
      compare_field("row_len_out", want.row_len_out, got.row_len_out);
      compare_field("byte_out", want.byte_out, got.byte_out);
      compare_field("slot_count", want.slot_count, got.slot_count);
      compare_field("free_bytes", want.free_bytes, got.free_bytes);
      compare_field("dirty", want.dirty, got.dirty);
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [REQ_TYPE_W-1:0]    req_type_i = '0;
  logic [SLOT_INDEX_W-1:0]  slot_index_i = '0;
  logic [ROW_LEN_W-1:0]     row_len_i = '0;
  logic [DATA_BYTE_W-1:0]   data_byte_i = '0;
  logic [BYTE_INDEX_W-1:0]  byte_index_i = '0;
  logic [PAGE_ID_W-1:0]     page_id_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [STATUS_W-1:0]      status_o;
  logic [SLOT_OUT_W-1:0]    slot_out_o;
  logic [ROW_OFFSET_W-1:0]  row_offset_o;
  logic [ROW_LEN_OUT_W-1:0] row_len_out_o;
  logic [BYTE_OUT_W-1:0]    byte_out_o;
  logic [SLOT_COUNT_W-1:0]  slot_count_o;
  logic [FREE_BYTES_W-1:0]  free_bytes_o;
  logic                     dirty_o;

  page_scoreboard board;
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    quiet_cycles   = 0;

  slotted_page_row_store_unit #(
    .PAGE_BYTES  (PAGE_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_SLOTS   (MAX_SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .slot_index_i (slot_index_i),
    .row_len_i    (row_len_i),
    .data_byte_i  (data_byte_i),
    .byte_index_i (byte_index_i),
    .page_id_i    (page_id_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .slot_out_o   (slot_out_o),
    .row_offset_o (row_offset_o),
    .row_len_out_o(row_len_out_o),
    .byte_out_o   (byte_out_o),
    .slot_count_o (slot_count_o),
    .free_bytes_o (free_bytes_o),
    .dirty_o      (dirty_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Receive side: check each accepted reply, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_result({status_o, slot_out_o, row_offset_o, row_len_out_o, byte_out_o,
                          slot_count_o, free_bytes_o, dirty_o});
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Abort when neither side moves anything for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("slotted_page_row_store_unit_test: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic request_t make_req(req_e k, int unsigned s, int unsigned l,
                                        int unsigned d, int unsigned b, bit [31:0] p);
    request_t r;
    r.kind  = k;
    r.slot  = SLOT_INDEX_W'(s);
    r.len   = ROW_LEN_W'(l);
    r.dbyte = DATA_BYTE_W'(d);
    r.bidx  = BYTE_INDEX_W'(b);
    r.pid   = p;
    return r;
  endfunction

  // A read row byte must never land on a page byte that was never written since
  // reset; push such a read past the row end so it answers byte beyond row instead.
  function automatic request_t keep_reads_defined(request_t r);
    int unsigned pos;
    if (r.kind == REQ_READ_BYTE && board.slot_state(r.slot) == ST_OK &&
        r.bidx < board.slot_len[r.slot]) begin
      pos = board.slot_off[r.slot] + r.bidx;
      if (!board.byte_written[pos]) r.bidx = BYTE_INDEX_W'(board.slot_len[r.slot]);
    end
    return r;
  endfunction

  // Mostly short rows, a few long ones, and the odd zero length.
  function automatic int unsigned row_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return 0;
    if (roll < 66) return $urandom_range(1, 24);
    if (roll < 90) return $urandom_range(25, 300);
    if (roll < 98) return $urandom_range(301, 2000);
    return $urandom_range(2001, 4096);
  endfunction

  function automatic int unsigned pick_slot();
    if (board.used == 0 || $urandom_range(0, 99) < 15) return $urandom_range(0, 1023);
    return $urandom_range(0, board.used - 1);
  endfunction

  function automatic int unsigned pick_byte(int unsigned s);
    if (s < board.used && board.slot_len[s] != 0 && $urandom_range(0, 99) < 85)
      return $urandom_range(0, board.slot_len[s] - 1);
    return $urandom_range(0, 4095);
  endfunction

  function automatic int unsigned resize(int unsigned s);
    int unsigned cur;
    int unsigned roll;
    cur  = (s < board.used && board.slot_len[s] != 0) ? board.slot_len[s] : 8;
    roll = $urandom_range(0, 99);
    if (roll < 35) return $urandom_range(1, cur);
    if (roll < 80) return $urandom_range(cur + 1, cur + 24);
    if (roll < 88) return 0;
    return row_size();
  endfunction

  // Mostly complete insert/update streams with reads mixed in; the rest is noise.
  function automatic request_t random_request();
    request_t    r;
    int unsigned roll;
    r.kind  = REQ_READ;
    r.slot  = SLOT_INDEX_W'($urandom_range(0, 1023));
    r.len   = ROW_LEN_W'($urandom_range(0, 4096));
    r.dbyte = DATA_BYTE_W'($urandom);
    r.bidx  = BYTE_INDEX_W'($urandom);
    r.pid   = $urandom;
    roll = $urandom_range(0, 99);
    // Finish short rows byte by byte; long rows are mostly abandoned midway.
    if (board.pend != 0 && roll < ((board.pend <= 32) ? 85 : 10)) begin
      r.kind = REQ_DATA;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 1 || (board.room() < 48 && roll < 20)) begin
        r.kind = REQ_INIT;
      end else if (roll < 28) begin
        r.kind = REQ_INSERT;
        r.len  = ROW_LEN_W'(row_size());
      end else if (roll < 43) begin
        r.slot = SLOT_INDEX_W'(pick_slot());
      end else if (roll < 65) begin
        r.kind = REQ_READ_BYTE;
        r.slot = SLOT_INDEX_W'(pick_slot());
        r.bidx = BYTE_INDEX_W'(pick_byte(r.slot));
      end else if (roll < 73) begin
        r.kind = REQ_DELETE;
        r.slot = SLOT_INDEX_W'(pick_slot());
      end else if (roll < 88) begin
        r.kind = REQ_UPDATE;
        r.slot = SLOT_INDEX_W'(pick_slot());
        r.len  = ROW_LEN_W'(resize(r.slot));
      end else begin
        r.kind = req_e'($urandom_range(0, 6));
      end
    end
    return keep_reads_defined(r);
  endfunction

  // Hold valid until the request is taken; note it at the accepting edge.
  task automatic send(request_t r);
    r = keep_reads_defined(r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_type_i   <= r.kind;
    slot_index_i <= r.slot;
    row_len_i    <= r.len;
    data_byte_i  <= r.dbyte;
    byte_index_i <= r.bidx;
    page_id_i    <= r.pid;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(r);
  endtask

  // Drop valid and wait until every owed reply is back.
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.owed_replies.size() != 0);
  endtask

  task automatic run_directed();
    send(make_req(REQ_INIT, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send(make_req(REQ_DATA, 0, 0, 8'h00, 0, 0));         // nothing pending yet
    send(make_req(REQ_INSERT, 0, 0, 0, 0, 0));           // zero length
    send(make_req(REQ_INSERT, 0, 4096, 0, 0, 0));        // as large as the page
    send(make_req(REQ_READ, 1023, 0, 0, 0, 0));          // slot out of bounds
    send(make_req(REQ_INSERT, 0, 3, 0, 0, 0));
    send(make_req(REQ_DATA, 0, 0, 8'h00, 0, 0));
    send(make_req(REQ_DATA, 0, 0, 8'hFF, 0, 0));
    send(make_req(REQ_DATA, 0, 0, 8'hA5, 0, 0));
    send(make_req(REQ_READ_BYTE, 0, 0, 0, 2, 0));
    send(make_req(REQ_READ_BYTE, 0, 0, 0, 4095, 0));     // beyond the row
    send(make_req(REQ_UPDATE, 0, 0, 0, 0, 0));           // zero length on a live slot
    send(make_req(REQ_UPDATE, 0, 2, 0, 0, 0));           // shrink in place
    send(make_req(REQ_DATA, 0, 0, 8'h5A, 0, 0));
    send(make_req(REQ_UPDATE, 0, 6, 0, 0, 0));           // grow, row moves
    send(make_req(REQ_DATA, 0, 0, 8'h81, 0, 0));
    send(make_req(REQ_READ, 0, 0, 0, 0, 0));
    send(make_req(REQ_INSERT, 0, 4070, 0, 0, 0));        // nearly fills the page
    send(make_req(REQ_UPDATE, 0, 100, 0, 0, 0));         // growth without room
    send(make_req(REQ_INSERT, 0, 1, 0, 0, 0));           // fits exactly
    send(make_req(REQ_INSERT, 0, 1, 0, 0, 0));           // no room left
    send(make_req(REQ_DELETE, 0, 0, 0, 0, 0));
    send(make_req(REQ_READ, 0, 0, 0, 0, 0));             // deleted slot
    send(make_req(REQ_READ_BYTE, 0, 0, 0, 0, 0));
    send(make_req(REQ_UPDATE, 0, 1, 0, 0, 0));
    send(make_req(REQ_INIT, 0, 0, 0, 0, 32'h0));
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: sender idles often, receiver stalls more often.
    send_idle_pct  = 35;
    recv_stall_pct = 46;
    run_directed();

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        drain_replies();
        send_idle_pct  = 46;
        recv_stall_pct = 35;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        // Last phase: back-to-back requests, receiver always ready.
        drain_replies();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else if ($urandom_range(0, 199) == 0) begin
        drain_replies();
      end
      send(random_request());
    end

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("slotted_page_row_store_unit_test: clean");
    end else begin
      $display("slotted_page_row_store_unit_test: errors");
    end
    $finish;
  end

endmodule
